// ===== hw/rtl/nlpw_pkg.sv =====
// ----------------------------------------------------------------------------
// nlpw_pkg: shared types and constants
// Codes, record widths and controller/datapath interface structs for the
// node liveness watchdog.
// ----------------------------------------------------------------------------
package nlpw_pkg;

    localparam int NODES   = 6;
    localparam int NODE_W  = 3;
    localparam int ID_W    = 11;
    localparam int TIME_W  = 32;
    localparam int SEQ_W   = 8;
    localparam int IDS_W   = 33;
    localparam int Q_DEPTH = 12;
    localparam int Q_W     = 4;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // result kinds
    localparam logic [1:0] K_PROBE = 2'd0;
    localparam logic [1:0] K_FAULT = 2'd1;
    localparam logic [1:0] K_CLEAR = 2'd2;

    // config register indexes
    localparam logic [2:0] CFG_PROBE_EN  = 3'd0;
    localparam logic [2:0] CFG_MON_LO    = 3'd1;
    localparam logic [2:0] CFG_MON_HI    = 3'd2;
    localparam logic [2:0] CFG_STATUS    = 3'd3;
    localparam logic [2:0] CFG_SILENCE   = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd5;
    localparam logic [2:0] CFG_GAP       = 3'd6;
    localparam logic [2:0] CFG_REVAL     = 3'd7;

    localparam logic [7:0] GOOD_TYPE   = 8'h00;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // datapath commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_LOAD    = 3'd1;
    localparam logic [2:0] CMD_START   = 3'd2;
    localparam logic [2:0] CMD_TICK_A  = 3'd3;
    localparam logic [2:0] CMD_TICK_B  = 3'd4;
    localparam logic [2:0] CMD_FRAME_M = 3'd5;
    localparam logic [2:0] CMD_FRAME_G = 3'd6;
    localparam logic [2:0] CMD_DRAIN   = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [NODE_W-1:0] node;
    } t_cmd;

    typedef struct packed {
        logic watch_en;
        logic drain_done;
    } t_status;

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       node;
        logic [SEQ_W-1:0] seq;
        logic [1:0]       sub;
        logic [2:0]       det;
        logic             shown;
    } t_result;

endpackage

// ===== hw/rtl/nlpw_ctrl.sv =====
// ----------------------------------------------------------------------------
// nlpw_ctrl: sequencing controller
// Walks the node records for start and tick requests, runs the two frame
// steps, then drains the result queue.
// ----------------------------------------------------------------------------
module nlpw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_opcode,
    input  nlpw_pkg::t_status i_status,
    output logic              o_in_ready,
    output nlpw_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START   = 3'd1;
    localparam logic [2:0] S_TICK_A  = 3'd2;
    localparam logic [2:0] S_TICK_B  = 3'd3;
    localparam logic [2:0] S_FRAME_M = 3'd4;
    localparam logic [2:0] S_FRAME_G = 3'd5;
    localparam logic [2:0] S_DRAIN   = 3'd6;

    localparam logic [nlpw_pkg::NODE_W-1:0] LAST_NODE =
        nlpw_pkg::NODE_W'(nlpw_pkg::NODES - 1);

    logic [2:0]                  r_state, n_state;
    logic [nlpw_pkg::NODE_W-1:0] r_node, n_node;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        o_cmd.op   = nlpw_pkg::CMD_NONE;
        o_cmd.node = r_node;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = nlpw_pkg::CMD_LOAD;
                    n_node   = '0;
                    if (i_opcode == nlpw_pkg::OP_START) begin
                        n_state = S_START;
                    end else if (i_opcode == nlpw_pkg::OP_FRAME && i_status.watch_en) begin
                        n_state = S_FRAME_M;
                    end else if (i_opcode == nlpw_pkg::OP_TICK && i_status.watch_en) begin
                        n_state = S_TICK_A;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_START: begin
                o_cmd.op = nlpw_pkg::CMD_START;
                if (r_node == LAST_NODE) begin
                    n_state = S_DRAIN;
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            S_TICK_A: begin
                o_cmd.op = nlpw_pkg::CMD_TICK_A;
                n_state  = S_TICK_B;
            end
            S_TICK_B: begin
                o_cmd.op = nlpw_pkg::CMD_TICK_B;
                if (r_node == LAST_NODE) begin
                    n_state = S_DRAIN;
                end else begin
                    n_node  = r_node + 1'b1;
                    n_state = S_TICK_A;
                end
            end
            S_FRAME_M: begin
                o_cmd.op = nlpw_pkg::CMD_FRAME_M;
                n_state  = S_FRAME_G;
            end
            S_FRAME_G: begin
                o_cmd.op = nlpw_pkg::CMD_FRAME_G;
                n_state  = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.op = nlpw_pkg::CMD_DRAIN;
                if (i_status.drain_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node  <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
        end
    end

endmodule

// ===== hw/rtl/nlpw_dp.sv =====
// ----------------------------------------------------------------------------
// nlpw_dp: watchdog datapath
// Config registers, per-node records, one record step per command, result
// queue and output register.
// ----------------------------------------------------------------------------
module nlpw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nlpw_pkg::t_cmd                i_cmd,
    output nlpw_pkg::t_status             o_status,
    input  logic                          i_cfg_valid,
    input  logic [2:0]                    i_cfg_index,
    input  logic [nlpw_pkg::IDS_W-1:0]    i_cfg_data,
    input  logic [nlpw_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [nlpw_pkg::ID_W-1:0]     i_frame_id,
    input  logic [3:0]                    i_frame_length,
    input  logic [7:0]                    i_type_byte,
    input  logic [7:0]                    i_param_byte,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output nlpw_pkg::t_result             o_out,
    output logic                          o_out_last
);

    localparam int TW = nlpw_pkg::TIME_W;
    localparam int IW = nlpw_pkg::ID_W;
    localparam int NW = nlpw_pkg::NODE_W;
    localparam int N  = nlpw_pkg::NODES;

    // config
    logic                         r_probe_en;
    logic [nlpw_pkg::IDS_W-1:0]   r_mon_lo, r_mon_hi, r_stat_ids;
    logic [TW-1:0]                r_silence, r_timeout, r_gap, r_reval;

    // captured request
    logic [TW-1:0] r_now;
    logic [IW-1:0] r_id;
    logic [3:0]    r_len;
    logic [7:0]    r_type, r_param;

    // node records
    logic                      r_watch_en;
    logic [N-1:0]              r_alarmed, r_waiting, r_missing;
    logic [TW-1:0]             r_ltt [N];
    logic [TW-1:0]             r_dl  [N];
    logic [TW-1:0]             r_lpt [N];
    logic [TW-1:0]             r_lvt [N];
    logic [nlpw_pkg::SEQ_W-1:0] r_cnt [N];
    logic [3:0]                r_flags;

    // result queue
    nlpw_pkg::t_result r_q [nlpw_pkg::Q_DEPTH];
    logic [nlpw_pkg::Q_W-1:0] r_wr, r_rd;
    nlpw_pkg::t_result r_out;
    logic r_out_valid, r_out_last;

    // step decode
    logic [NW-1:0] act;
    logic          start_rec, want_probe, set_missing, clr_missing, upd_lvt;
    logic          set_ltt, end_wait, set_alarm, mark_good, show_en, show_alarm;
    logic          probe_ok, do_probe, push, pop;
    logic [TW-1:0] d_ltt, d_lpt, d_lvt;
    logic [3:0]    flags_base, flags_new;
    logic          found;
    logic [NW-1:0] match_idx;
    logic [IW-1:0] mid;
    logic [3:0]    good_d;
    nlpw_pkg::t_result probe_res, show_res, push_data;

    always_comb begin
        found     = 1'b0;
        match_idx = '0;
        mid       = '0;
        for (int j = N - 1; j >= 0; j--) begin
            mid = (j < 3) ? r_mon_lo[IW*(j%3) +: IW] : r_mon_hi[IW*(j%3) +: IW];
            if (mid != '0 && mid == r_id) begin
                found     = 1'b1;
                match_idx = NW'(j);
            end
        end
    end

    assign good_d = r_param[3:0] & nlpw_pkg::NIBBLE_MASK;

    always_comb begin
        act         = i_cmd.node;
        start_rec   = 1'b0;
        want_probe  = 1'b0;
        set_missing = 1'b0;
        clr_missing = 1'b0;
        upd_lvt     = 1'b0;
        set_ltt     = 1'b0;
        end_wait    = 1'b0;
        set_alarm   = 1'b0;
        mark_good   = 1'b0;
        show_en     = 1'b0;
        show_alarm  = 1'b0;
        case (i_cmd.op)
            nlpw_pkg::CMD_START: begin
                start_rec  = 1'b1;
                show_en    = 1'b1;
                show_alarm = 1'b1;
            end
            nlpw_pkg::CMD_TICK_A: begin
                if (d_ltt > r_silence) begin
                    set_missing = 1'b1;
                    want_probe  = !r_waiting[act];
                end else if (r_alarmed[act] && !r_waiting[act] &&
                             d_lvt >= r_reval) begin
                    want_probe = 1'b1;
                    upd_lvt    = 1'b1;
                end
            end
            nlpw_pkg::CMD_TICK_B: begin
                if (r_waiting[act] && r_now >= r_dl[act]) begin
                    end_wait   = 1'b1;
                    set_alarm  = 1'b1;
                    show_en    = 1'b1;
                    show_alarm = 1'b1;
                end
            end
            nlpw_pkg::CMD_FRAME_M: begin
                act = match_idx;
                if (found) begin
                    set_ltt = 1'b1;
                    if (r_missing[match_idx]) begin
                        clr_missing = 1'b1;
                        want_probe  = 1'b1;
                    end
                end
            end
            nlpw_pkg::CMD_FRAME_G: begin
                if (r_len >= 4'd2 && r_type == nlpw_pkg::GOOD_TYPE) begin
                    if (r_id == r_stat_ids[0 +: IW]) begin
                        act       = NW'(4);
                        mark_good = (r_param == 8'd0);
                    end else if (r_id == r_stat_ids[IW +: IW]) begin
                        act       = NW'(5);
                        mark_good = (r_param == 8'd0);
                    end else if (r_id == r_stat_ids[2*IW +: IW]) begin
                        act       = NW'(good_d - 4'd1);
                        mark_good = (good_d >= 4'd1 && good_d <= 4'd4);
                    end
                end
                show_en = mark_good;
            end
            default: begin
            end
        endcase
    end

    assign d_lpt    = r_now - r_lpt[act];
    assign d_ltt    = r_now - r_ltt[act];
    assign d_lvt    = r_now - r_lvt[act];
    assign probe_ok = r_probe_en && (d_lpt >= r_gap);
    assign do_probe = want_probe && probe_ok;

    always_comb begin
        probe_res       = '0;
        probe_res.kind  = nlpw_pkg::K_PROBE;
        probe_res.node  = act + 1'b1;
        probe_res.seq   = r_cnt[act] + 1'b1;
    end

    // nodes 4 and 5 drive subsystems 1 and 2; subsystem 3 shows the lowest active MCU alarm
    always_comb begin
        flags_base = (start_rec && act == '0) ? nlpw_pkg::NIBBLE_MASK : r_flags;
        flags_new  = flags_base;
        show_res   = '0;
        if (act == NW'(4) || act == NW'(5)) begin
            show_res.kind = show_alarm ? nlpw_pkg::K_FAULT : nlpw_pkg::K_CLEAR;
            show_res.sub  = (act == NW'(4)) ? 2'd1 : 2'd2;
        end else begin
            if (show_alarm) begin
                flags_new = flags_base | (4'd1 << act[1:0]);
            end else begin
                flags_new = flags_base & ~(4'd1 << act[1:0]);
            end
            show_res.sub  = 2'd3;
            show_res.kind = nlpw_pkg::K_CLEAR;
            for (int d = 3; d >= 0; d--) begin
                if (flags_new[d]) begin
                    show_res.kind  = nlpw_pkg::K_FAULT;
                    show_res.det   = 3'(d + 1);
                    show_res.shown = 1'b1;
                end
            end
        end
    end

    assign push      = do_probe || show_en;
    assign push_data = do_probe ? probe_res : show_res;
    assign pop       = (i_cmd.op == nlpw_pkg::CMD_DRAIN) && (r_rd != r_wr) &&
                       (!r_out_valid || i_out_ready);

    assign o_status.watch_en   = r_watch_en;
    assign o_status.drain_done = (r_rd == r_wr);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_out_last  = r_out_last;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_en <= 1'b0;
            r_mon_lo   <= '0;
            r_mon_hi   <= '0;
            r_stat_ids <= '0;
            r_silence  <= TW'(1000);
            r_timeout  <= TW'(200);
            r_gap      <= TW'(100);
            r_reval    <= TW'(1000);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nlpw_pkg::CFG_PROBE_EN: r_probe_en <= i_cfg_data[0];
                nlpw_pkg::CFG_MON_LO:   r_mon_lo   <= i_cfg_data;
                nlpw_pkg::CFG_MON_HI:   r_mon_hi   <= i_cfg_data;
                nlpw_pkg::CFG_STATUS:   r_stat_ids <= i_cfg_data;
                nlpw_pkg::CFG_SILENCE:  r_silence  <= i_cfg_data[TW-1:0];
                nlpw_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TW-1:0];
                nlpw_pkg::CFG_GAP:      r_gap      <= i_cfg_data[TW-1:0];
                nlpw_pkg::CFG_REVAL:    r_reval    <= i_cfg_data[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == nlpw_pkg::CMD_LOAD) begin
            r_now   <= i_now_ms;
            r_id    <= i_frame_id;
            r_len   <= i_frame_length;
            r_type  <= i_type_byte;
            r_param <= i_param_byte;
        end
    end

    // node records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watch_en <= 1'b0;
            r_alarmed  <= '1;
            r_waiting  <= '0;
            r_missing  <= '1;
            r_flags    <= nlpw_pkg::NIBBLE_MASK;
            for (int i = 0; i < N; i++) begin
                r_ltt[i] <= '0;
                r_dl[i]  <= '0;
                r_lpt[i] <= '0;
                r_lvt[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (show_en) begin
                r_flags <= flags_new;
            end
            if (start_rec) begin
                r_watch_en     <= 1'b1;
                r_alarmed[act] <= 1'b1;
                r_waiting[act] <= 1'b0;
                r_missing[act] <= 1'b1;
                r_ltt[act]     <= r_now;
                r_dl[act]      <= '0;
                r_lpt[act]     <= '0;
                r_lvt[act]     <= '0;
                r_cnt[act]     <= '0;
            end
            if (set_missing) r_missing[act] <= 1'b1;
            if (clr_missing) r_missing[act] <= 1'b0;
            if (set_ltt)     r_ltt[act]     <= r_now;
            if (upd_lvt)     r_lvt[act]     <= r_now;
            if (do_probe) begin
                r_lpt[act]     <= r_now;
                r_cnt[act]     <= r_cnt[act] + 1'b1;
                r_waiting[act] <= 1'b1;
                r_dl[act]      <= r_now + r_timeout;
            end
            if (end_wait) r_waiting[act] <= 1'b0;
            if (set_alarm) r_alarmed[act] <= 1'b1;
            if (mark_good) begin
                r_waiting[act] <= 1'b0;
                r_missing[act] <= 1'b0;
                r_ltt[act]     <= r_now;
                r_lvt[act]     <= r_now;
                r_alarmed[act] <= 1'b0;
            end
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else if (i_cmd.op == nlpw_pkg::CMD_LOAD) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out      <= r_q[r_rd];
            r_out_last <= (r_rd + 1'b1 == r_wr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/node_liveness_probe_watchdog.sv =====
// ----------------------------------------------------------------------------
// node_liveness_probe_watchdog: liveness watchdog for six bus nodes
// Tracks traffic per node, sends rate-limited probe requests and reports
// alarm changes as LED fault/clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one request: a start, a
//   received frame or a time tick, stamped with i_now_ms. Output channel
//   (o_out_valid/i_out_ready) returns the results of that request in order;
//   o_last_result marks the final one. A request with no results returns none.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; write it only
//   while the block is idle.
// Timing:
//   A request is taken while idle; then start walks the six node records,
//   a tick takes two record steps for each of six nodes (one record step
//   per cycle), a frame its two steps, an ignored request none; then the
//   result queue drains and the block returns to idle. Results leave through an
//   output register, so the next request is taken while the last result
//   still waits. A stalled receiver holds the drain.
// Reset: synchronous, active low; config returns to its defaults, the
//   watchdog is stopped and all nodes read as alarmed and missing.
// ----------------------------------------------------------------------------
module node_liveness_probe_watchdog (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_now_ms,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_length,
    input  logic [7:0]  i_type_byte,
    input  logic [7:0]  i_param_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_target_node,
    output logic [7:0]  o_probe_sequence,
    output logic [1:0]  o_led_subsystem,
    output logic [2:0]  o_led_detail,
    output logic        o_detail_shown,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data
);

    nlpw_pkg::t_cmd    cmd;
    nlpw_pkg::t_status status;
    nlpw_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    nlpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    nlpw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_now_ms       (i_now_ms),
        .i_frame_id     (i_frame_id),
        .i_frame_length (i_frame_length),
        .i_type_byte    (i_type_byte),
        .i_param_byte   (i_param_byte),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out          (res),
        .o_out_last     (o_last_result)
    );

    assign o_kind           = res.kind;
    assign o_target_node    = res.node;
    assign o_probe_sequence = res.seq;
    assign o_led_subsystem  = res.sub;
    assign o_led_detail     = res.det;
    assign o_detail_shown   = res.shown;

endmodule

// ===== hw/rtl/nlpw_checker.sv =====
// ----------------------------------------------------------------------------
// nlpw_checker: port-level checks
// Watches the top level's channels and result fields over time.
// ----------------------------------------------------------------------------
module nlpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [2:0]  o_target_node,
    input logic [1:0]  o_led_subsystem,
    input logic [2:0]  o_led_detail,
    input logic        o_detail_shown
);

    // a result held under stall stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped under stall");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    a_probe_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == nlpw_pkg::K_PROBE |->
            o_target_node != 3'd0 && o_led_subsystem == 2'd0)
        else $error("probe result with LED fields");

    a_detail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_detail_shown |->
            o_led_subsystem == 2'd3 && o_kind == nlpw_pkg::K_FAULT && o_led_detail != 3'd0)
        else $error("detail outside MCU fault");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind node_liveness_probe_watchdog nlpw_checker u_nlpw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_kind          (o_kind),
    .o_target_node   (o_target_node),
    .o_led_subsystem (o_led_subsystem),
    .o_led_detail    (o_led_detail),
    .o_detail_shown  (o_detail_shown)
);
